>>> hw/rtl/fwmi_pkg.sv
`timescale 1ns / 1ps

package fwmi_pkg;

	// Geometry of each half's ring store
	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SUM_W    = CNT_W + 1;
	localparam int DATA_W   = 32;

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic signed [DATA_W-1:0] word_t;

	// Operation codes on the mode field
	localparam logic [1:0] MODE_PUSH_BACK = 2'd0;
	localparam logic [1:0] MODE_PUSH_MID  = 2'd1;
	localparam logic [1:0] MODE_POP       = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic fin;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_fin;
		logic has_result;
	} status_t;

	// Ring index plus offset, wrapped once at CAPACITY
	function automatic idx_t ring_add(idx_t base, cnt_t off);
		logic [SUM_W-1:0] s;
		s = {{(SUM_W - IDX_W){1'b0}}, base} + {1'b0, off};
		if (s >= SUM_W'(CAPACITY)) begin
			s = s - SUM_W'(CAPACITY);
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic idx_t ring_inc(idx_t base);
		return ring_add(base, CNT_W'(1));
	endfunction

	function automatic idx_t ring_dec(idx_t base);
		return (base == '0) ? IDX_W'(CAPACITY - 1) : base - IDX_W'(1);
	endfunction

endpackage

>>> hw/rtl/fwmi_ctrl.sv
`timescale 1ns / 1ps

module fwmi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  fwmi_pkg::status_t   status,
	output fwmi_pkg::cmd_t      cmd,
	output logic                busy,
	output logic                done
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// Sequence: accept, execute, optional finish beat
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = status.need_fin ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Drive commands and handshake
	assign cmd.load = (state_q == ST_IDLE) && start;
	assign cmd.exec = (state_q == ST_EXEC);
	assign cmd.fin  = (state_q == ST_FIN);
	assign busy     = (state_q != ST_IDLE);
	assign done     = (state_q == ST_FIN) && status.has_result;

endmodule

>>> hw/rtl/fwmi_dp.sv
`timescale 1ns / 1ps

module fwmi_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  fwmi_pkg::cmd_t      cmd,
	input  logic [1:0]          mode,
	input  fwmi_pkg::word_t     value,
	output fwmi_pkg::status_t   status,
	output fwmi_pkg::word_t     popped_value
);

	// Latched beat
	logic [1:0]      mode_q;
	fwmi_pkg::word_t value_q;

	// Ring pointers and counts
	fwmi_pkg::idx_t fh_q, bh_q, fh_d, bh_d;
	fwmi_pkg::cnt_t fc_q, bc_q, fc_d, bc_d;

	// Pending move and result
	logic           mv_q, res_q, src_front_q;
	logic           mv_d, res_d, src_front_d, fin_d;
	fwmi_pkg::idx_t mv_addr_q, mv_addr_d;

	// Memory ports
	logic            f_we, f_re, b_we, b_re;
	fwmi_pkg::idx_t  f_waddr, f_raddr, b_waddr, b_raddr;
	fwmi_pkg::word_t f_wdata, b_wdata;
	fwmi_pkg::word_t front_rd_q, back_rd_q;

	fwmi_pkg::word_t front_mem [fwmi_pkg::CAPACITY];
	fwmi_pkg::word_t back_mem  [fwmi_pkg::CAPACITY];

	logic [fwmi_pkg::SUM_W-1:0] total;
	logic                       full, eq;
	fwmi_pkg::idx_t             ft, bt;

	assign total = {1'b0, fc_q} + {1'b0, bc_q};
	assign full  = (total >= fwmi_pkg::SUM_W'(fwmi_pkg::CAPACITY));
	assign eq    = (fc_q == bc_q);
	assign ft    = fwmi_pkg::ring_add(fh_q, fc_q);
	assign bt    = fwmi_pkg::ring_add(bh_q, bc_q);

	// Latch the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			value_q <= value;
		end
	end

	// Decode the operation and its rebalance move
	always_comb begin
		fh_d        = fh_q;
		bh_d        = bh_q;
		fc_d        = fc_q;
		bc_d        = bc_q;
		mv_d        = 1'b0;
		res_d       = 1'b0;
		src_front_d = 1'b0;
		fin_d       = 1'b0;
		mv_addr_d   = ft;
		f_we        = 1'b0;
		f_re        = 1'b0;
		b_we        = 1'b0;
		b_re        = 1'b0;
		f_waddr     = ft;
		f_raddr     = fh_q;
		b_waddr     = bt;
		b_raddr     = bh_q;
		f_wdata     = value_q;
		b_wdata     = value_q;
		if (cmd.exec) begin
			unique case (mode_q)
				fwmi_pkg::MODE_PUSH_BACK: begin
					if (!full) begin
						if (eq && (bc_q == '0)) begin
							// empty queue: the new beat lands straight in the front half
							f_we = 1'b1;
							fc_d = fc_q + fwmi_pkg::CNT_W'(1);
						end else if (eq) begin
							// append at back, move back head to front tail in the finish state
							b_we  = 1'b1;
							b_re  = 1'b1;
							bh_d  = fwmi_pkg::ring_inc(bh_q);
							fc_d  = fc_q + fwmi_pkg::CNT_W'(1);
							mv_d  = 1'b1;
							fin_d = 1'b1;
						end else begin
							b_we = 1'b1;
							bc_d = bc_q + fwmi_pkg::CNT_W'(1);
						end
					end
				end
				fwmi_pkg::MODE_PUSH_MID: begin
					if (!full) begin
						if (!eq) begin
							// front already one ahead: new tail goes to back head
							b_we    = 1'b1;
							b_waddr = fwmi_pkg::ring_dec(bh_q);
							bh_d    = fwmi_pkg::ring_dec(bh_q);
							bc_d    = bc_q + fwmi_pkg::CNT_W'(1);
						end else begin
							f_we = 1'b1;
							fc_d = fc_q + fwmi_pkg::CNT_W'(1);
						end
					end
				end
				fwmi_pkg::MODE_POP: begin
					if (fc_q != '0) begin
						f_re        = 1'b1;
						fh_d        = fwmi_pkg::ring_inc(fh_q);
						res_d       = 1'b1;
						src_front_d = 1'b1;
						fin_d       = 1'b1;
						if (eq) begin
							// refill front tail from back head
							b_re = 1'b1;
							bh_d = fwmi_pkg::ring_inc(bh_q);
							bc_d = bc_q - fwmi_pkg::CNT_W'(1);
							mv_d = 1'b1;
						end else begin
							fc_d = fc_q - fwmi_pkg::CNT_W'(1);
						end
					end else if (bc_q != '0) begin
						b_re  = 1'b1;
						bh_d  = fwmi_pkg::ring_inc(bh_q);
						bc_d  = bc_q - fwmi_pkg::CNT_W'(1);
						res_d = 1'b1;
						fin_d = 1'b1;
					end
				end
				default: ;
			endcase
		end else if (cmd.fin && mv_q) begin
			// write the moved entry at the front tail
			f_we    = 1'b1;
			f_waddr = mv_addr_q;
			f_wdata = back_rd_q;
		end
	end

	// Update pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q  <= '0;
			bh_q  <= '0;
			fc_q  <= '0;
			bc_q  <= '0;
			mv_q  <= 1'b0;
			res_q <= 1'b0;
		end else if (cmd.exec) begin
			fh_q  <= fh_d;
			bh_q  <= bh_d;
			fc_q  <= fc_d;
			bc_q  <= bc_d;
			mv_q  <= mv_d;
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			src_front_q <= src_front_d;
			mv_addr_q   <= mv_addr_d;
		end
	end

	// Front half store
	always_ff @(posedge clk) begin
		if (f_we) front_mem[f_waddr] <= f_wdata;
		if (f_re) front_rd_q <= front_mem[f_raddr];
	end

	// Back half store
	always_ff @(posedge clk) begin
		if (b_we) back_mem[b_waddr] <= b_wdata;
		if (b_re) back_rd_q <= back_mem[b_raddr];
	end

	assign status.need_fin   = fin_d;
	assign status.has_result = res_q;
	assign popped_value      = src_front_q ? front_rd_q : back_rd_q;

endmodule

>>> hw/rtl/fifo_with_middle_insert.sv
`timescale 1ns / 1ps
// A pop result strobes on done in the finish state, after the execute state of the taken start beat.
// A new beat is taken only once the block is idle again; the finish state follows the execute
// state when a pop takes a value or a push at the back moves an entry to the front store.
// The receiver cannot stall; done is high for exactly one cycle per result.
// Reset clears the ring heads and counts; the stores are not cleared and need no pass.
module fifo_with_middle_insert (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          mode,
	input  fwmi_pkg::word_t     value,
	output logic                done,
	output fwmi_pkg::word_t     popped_value
);

	fwmi_pkg::cmd_t    cmd;
	fwmi_pkg::status_t status;

	// Sequence the beat
	fwmi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Hold both halves and move entries
	fwmi_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (mode),
		.value        (value),
		.status       (status),
		.popped_value (popped_value)
	);

endmodule

>>> bench/fwmi_checker.sv
`timescale 1ns / 1ps

module fwmi_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  logic [1:0]      mode,
	input  fwmi_pkg::word_t value,
	input  logic            done,
	input  fwmi_pkg::word_t popped_value,
	output int              fail_count,
	output int              pending
);
	import fwmi_pkg::*;

	// Mirror of the two halves: ring stores, heads and counts
	word_t front_mem [CAPACITY];
	word_t back_mem  [CAPACITY];
	idx_t  front_head = '0;
	idx_t  back_head  = '0;
	cnt_t  front_cnt  = '0;
	cnt_t  back_cnt   = '0;

	// Values due on popped_value, oldest first
	word_t popped_due [$];
	int    errors = 0;

	function automatic idx_t slot(idx_t base, int off);
		return idx_t'((int'(base) + off) % CAPACITY);
	endfunction

	// Move at most one entry across the boundary so front holds back or back + 1
	function void balance_halves();
		word_t moved;
		if (int'(front_cnt) > int'(back_cnt) + 1) begin
			moved = front_mem[slot(front_head, int'(front_cnt) - 1)];
			front_cnt--;
			back_head = slot(back_head, CAPACITY - 1);
			back_mem[back_head] = moved;
			back_cnt++;
		end else if (back_cnt > front_cnt) begin
			moved = back_mem[back_head];
			back_head = slot(back_head, 1);
			back_cnt--;
			front_mem[slot(front_head, int'(front_cnt))] = moved;
			front_cnt++;
		end
	endfunction

	// Apply one accepted beat; queue the popped value if a pop takes one
	function void apply_beat(logic [1:0] op, word_t data);
		word_t taken;
		case (op)
			MODE_PUSH_BACK, MODE_PUSH_MID: begin
				// drop pushes into a full queue
				if (int'(front_cnt) + int'(back_cnt) < CAPACITY) begin
					if (op == MODE_PUSH_BACK) begin
						back_mem[slot(back_head, int'(back_cnt))] = data;
						back_cnt++;
					end else begin
						front_mem[slot(front_head, int'(front_cnt))] = data;
						front_cnt++;
					end
					balance_halves();
				end
			end
			MODE_POP: begin
				// take from front half, or from back half when front is empty
				if (front_cnt != 0) begin
					taken = front_mem[front_head];
					front_head = slot(front_head, 1);
					front_cnt--;
					balance_halves();
					popped_due.push_back(taken);
				end else if (back_cnt != 0) begin
					taken = back_mem[back_head];
					back_head = slot(back_head, 1);
					back_cnt--;
					balance_halves();
					popped_due.push_back(taken);
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, word_t got, word_t want);
		$display("%0t ns: %s: popped_value %0d (0x%08h), expected %0d (0x%08h)",
			$time, what, got, got, want, want);
		errors++;
	endtask

	// Watch both channels at each edge; compare each result beat with the oldest due value
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				apply_beat(mode, value);
			end
			if (done) begin
				if (popped_due.size() == 0) begin
					report_mismatch("result beat with nothing due", popped_value, '0);
				end else begin
					if (popped_value !== popped_due[0]) begin
						report_mismatch("wrong popped value", popped_value, popped_due[0]);
					end
					void'(popped_due.pop_front());
				end
			end
		end
		fail_count <= errors;
		pending    <= popped_due.size();
	end

endmodule

>>> bench/tb_fifo_with_middle_insert.sv
`timescale 1ns / 1ps

module tb_fifo_with_middle_insert;
	import fwmi_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	logic [1:0]  mode   = MODE_PUSH_BACK;
	word_t       value  = '0;
	logic        busy;
	logic        done;
	word_t       popped_value;
	int          fail_count;
	int          pending;

	// Occupancy as seen from the stimulus side, used only to steer the phases
	int          level        = 0;
	int          quiet_cycles = 0;
	bit          idle_ok      = 1'b1;

	word_t extreme_words [6] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000,
		32'shffff_ffff, 32'sh5555_5555, 32'shaaaa_aaaa};

	always #5 clk = ~clk;

	fifo_with_middle_insert dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.value        (value),
		.done         (done),
		.popped_value (popped_value)
	);

	fwmi_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.value        (value),
		.done         (done),
		.popped_value (popped_value),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Present one beat and hold it until the block takes it
	task automatic issue(logic [1:0] op, word_t data);
		start <= 1'b1;
		mode  <= op;
		value <= data;
		do @(posedge clk); while (busy);
		if ((op == MODE_PUSH_BACK || op == MODE_PUSH_MID) && level < CAPACITY) begin
			level++;
		end else if (op == MODE_POP && level > 0) begin
			level--;
		end
	endtask

	// Drop start for a random burst now and then
	task automatic gap_burst();
		if (idle_ok && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	function automatic word_t pick_word();
		case ($urandom_range(0, 7))
			0: begin
				return extreme_words[$urandom_range(0, 5)];
			end
			default: begin
				return word_t'($urandom);
			end
		endcase
	endfunction

	function automatic logic [1:0] pick_push();
		return $urandom_range(0, 1) ? MODE_PUSH_MID : MODE_PUSH_BACK;
	endfunction

	function automatic logic [1:0] pick_mode(int pop_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < pop_pct) begin
			return MODE_POP;
		end else if (r < 97) begin
			return pick_push();
		end
		return MODE_UNUSED;
	endfunction

	// Stop the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue: pop gives nothing, unused mode does nothing
		issue(MODE_POP, 32'sh1234_5678);
		issue(MODE_UNUSED, 32'shffff_ffff);

		// Extreme values alternately at back and middle
		foreach (extreme_words[i]) begin
			issue((i % 2 == 0) ? MODE_PUSH_BACK : MODE_PUSH_MID, extreme_words[i]);
		end
		issue(MODE_UNUSED, 32'sh1234_5678);

		// Drain it, then pop once more on empty
		repeat (7) issue(MODE_POP, '0);
		issue(MODE_PUSH_BACK, 32'sh0000_0001);
		issue(MODE_POP, '0);

		// Fill to capacity, then push into the full queue
		while (level < CAPACITY) begin
			issue(pick_push(), pick_word());
			gap_burst();
		end
		repeat (6) begin
			issue(pick_push(), pick_word());
			gap_burst();
		end

		// Hover near full
		repeat (150) begin
			issue(pick_mode(45), pick_word());
			gap_burst();
		end

		// Drain to empty; the heads wrap on the way down
		while (level > 0) begin
			issue(pick_mode(95), pick_word());
			gap_burst();
		end
		repeat (3) issue(MODE_POP, pick_word());

		// Back-to-back beats at low occupancy
		idle_ok = 1'b0;
		repeat (150) issue(pick_mode(50), pick_word());
		start <= 1'b0;

		// Wait out the last results
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);

		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
